[rtl/lsra_pkg.sv]
// Shared types and constants for the linear scan register allocator.
// No dependencies.
package lsra_pkg;

  localparam int ACTIVE_DEPTH = 16;
  localparam int ACT_IDX_W    = 4;
  localparam int ACT_CNT_W    = 5;
  localparam int POS_W        = 10;
  localparam int TYPE_W       = 2;
  localparam int MASK_W       = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE3 = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch the input item
    logic expire;    // drop expired ranges from the head of the active list
    logic decide;    // pick register / victim / slot, update state
    logic emit0;     // drive first result
    logic emit1;     // drive second result
  } lsra_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic two_results;
  } lsra_stat_t;

endpackage

[rtl/lsra_ctrl.sv]
// Sequencing state machine for the allocator.
// Depends on lsra_pkg.
module lsra_ctrl import lsra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  lsra_stat_t stat,
  output logic       busy,
  output lsra_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXPIRE = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EMIT0  = 3'd3;
  localparam logic [2:0] S_EMIT1  = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        cmd.expire = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT0;
      end
      S_EMIT0: begin
        cmd.emit0 = 1'b1;
        state_next = stat.two_results ? S_EMIT1 : S_IDLE;
      end
      S_EMIT1: begin
        cmd.emit1 = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  a_emit1_after_emit0: assert property (@(posedge clk) disable iff (rst)
    cmd.emit1 |-> $past(cmd.emit0)) else $error("second result without first");
  a_decide_after_expire: assert property (@(posedge clk) disable iff (rst)
    cmd.expire |=> cmd.decide) else $error("decide did not follow expire");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy) else $error("busy not raised after load");

endmodule

[rtl/lsra_dp.sv]
// Datapath: config registers, active list, free map, slot counter, results.
// Depends on lsra_pkg.
module lsra_dp import lsra_pkg::*; #(
  parameter int NUM_REGS   = 16,
  parameter int MAX_VALUES = 1024,
  parameter int NUM_TYPES  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lsra_cmd_t            cmd,
  output lsra_stat_t           stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  input  logic [POS_W-1:0]     range_start,
  input  logic [POS_W-1:0]     range_end,
  input  logic [TYPE_W-1:0]    value_type,
  output logic                 result_valid,
  output logic [POS_W-1:0]     value_index,
  output logic                 in_register,
  output logic [3:0]           register_number,
  output logic [POS_W-1:0]     stack_slot,
  output logic                 last_result
);

  localparam int NR = (NUM_REGS >= 16) ? 16 : NUM_REGS;
  localparam logic [MASK_W-1:0] REG_LIMIT = (NUM_REGS >= 16) ? 16'hFFFF
                                            : MASK_W'((1 << NR) - 1);
  localparam logic [POS_W-1:0] SLOT_TOP = (MAX_VALUES >= 1024) ? 10'd1023
                                          : POS_W'(MAX_VALUES - 1);

  typedef struct packed {
    logic [POS_W-1:0] st;
    logic [POS_W-1:0] en;
    logic [3:0]       rg;
  } entry_t;

  logic [MASK_W-1:0] pool_mask, free_map;
  logic [MASK_W-1:0] type_mask [4];
  entry_t            act [ACTIVE_DEPTH];
  logic [ACT_CNT_W-1:0] act_cnt;
  logic [POS_W-1:0]  slot_cnt;
  logic [POS_W-1:0]  cur_st, cur_en;
  logic [TYPE_W-1:0] cur_ty;

  // result registers
  logic [POS_W-1:0] r0_val, r1_val, r0_slot, r1_slot;
  logic             r0_inreg, r_two;
  logic [3:0]       r0_reg;

  // expire: expired entries are a prefix, since the list is sorted by end
  logic [ACTIVE_DEPTH-1:0] exp_v;
  logic [ACT_CNT_W-1:0]    gone;
  logic [MASK_W-1:0]       freed;
  always_comb begin
    freed = '0;
    gone  = '0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      exp_v[i] = (ACT_CNT_W'(i) < act_cnt) && (act[i].en < cur_st);
      if (exp_v[i]) begin
        freed = freed | (MASK_W'(1) << act[i].rg);
        gone  = gone + ACT_CNT_W'(1);
      end
    end
  end

  // decide
  logic [MASK_W-1:0] suit, cand;
  logic [3:0]        low_r;
  logic              use_free, use_victim;
  entry_t            last_e;
  always_comb begin
    suit = (32'(cur_ty) < NUM_TYPES) ? type_mask[cur_ty] : '0;
    cand = free_map & suit & REG_LIMIT;
    low_r = '0;
    for (int r = 15; r >= 0; r--) if (cand[r]) low_r = 4'(r);
    last_e = act[ACT_IDX_W'(act_cnt - ACT_CNT_W'(1))];
    use_free   = (cand != '0) && (act_cnt < ACT_CNT_W'(ACTIVE_DEPTH));
    use_victim = !use_free && (act_cnt != '0) && (last_e.en > cur_en);
  end

  // sorted insert of the new range; base count is act_cnt (minus one for victim)
  logic [ACT_CNT_W-1:0] base;
  logic [3:0]           new_rg;
  entry_t               ins [ACTIVE_DEPTH];
  always_comb begin
    base   = use_victim ? act_cnt - ACT_CNT_W'(1) : act_cnt;
    new_rg = use_victim ? last_e.rg : low_r;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      if (ACT_CNT_W'(i) < base && act[i].en <= cur_en)
        ins[i] = act[i];
      else if (ACT_CNT_W'(i) > 0 && ACT_CNT_W'(i) <= base
               && act[(i + ACTIVE_DEPTH - 1) % ACTIVE_DEPTH].en > cur_en)
        ins[i] = act[(i + ACTIVE_DEPTH - 1) % ACTIVE_DEPTH];
      else if (ACT_CNT_W'(i) <= base)
        ins[i] = '{st: cur_st, en: cur_en, rg: new_rg};
      else
        ins[i] = act[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mask <= '1;
      free_map  <= '1;
      for (int t = 0; t < 4; t++) type_mask[t] <= '1;
      act_cnt   <= '0;
      slot_cnt  <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POOL: begin
            pool_mask <= cfg_data;
            free_map  <= cfg_data & REG_LIMIT;
          end
          CFG_TYPE0: type_mask[0] <= cfg_data;
          CFG_TYPE1: type_mask[1] <= cfg_data;
          CFG_TYPE2: type_mask[2] <= cfg_data;
          CFG_TYPE3: type_mask[3] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        cur_st <= range_start;
        cur_en <= range_end;
        cur_ty <= value_type;
      end
      if (cmd.expire) begin
        free_map <= free_map | (freed & pool_mask);
        for (int i = 0; i < ACTIVE_DEPTH; i++)
          act[i] <= act[ACT_IDX_W'(ACT_CNT_W'(i) + gone)];
        act_cnt <= act_cnt - gone;
      end
      if (cmd.decide) begin
        r0_val <= cur_st;
        r_two  <= use_victim;
        r1_val <= last_e.st;
        if (use_free || use_victim) begin
          if (use_free) free_map <= free_map & ~(MASK_W'(1) << low_r);
          for (int i = 0; i < ACTIVE_DEPTH; i++) act[i] <= ins[i];
          act_cnt <= base + ACT_CNT_W'(1);
          r0_inreg <= 1'b1;
          r0_reg   <= new_rg;
          r0_slot  <= '0;
        end else begin
          r0_inreg <= 1'b0;
          r0_reg   <= '0;
          r0_slot  <= slot_cnt;
        end
        r1_slot <= slot_cnt;
        if (!use_free && slot_cnt < SLOT_TOP) slot_cnt <= slot_cnt + POS_W'(1);
      end
      if (cmd.emit0 || cmd.emit1) result_valid <= 1'b1;
      if (cmd.emit0) begin
        value_index     <= r0_val;
        in_register     <= r0_inreg;
        register_number <= r0_reg;
        stack_slot      <= r0_slot;
        last_result     <= !r_two;
      end
      if (cmd.emit1) begin
        value_index     <= r1_val;
        in_register     <= 1'b0;
        register_number <= '0;
        stack_slot      <= r1_slot;
        last_result     <= 1'b1;
      end
    end
  end

  assign stat.two_results = r_two;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    act_cnt <= ACT_CNT_W'(ACTIVE_DEPTH)) else $error("active count overflow");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_cnt <= SLOT_TOP) else $error("slot counter past top");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !in_register) |-> last_result)
    else $error("stack result not last");

endmodule

[rtl/linear_scan_register_allocator.sv]
// Top level of the linear scan register allocator: controller plus datapath.
// Depends on lsra_pkg, lsra_ctrl, lsra_dp.
//
// Each live range (start, end, type) is taken when start is high and busy is
// low, ranges in rising start order. An item passes through load, expiry of the
// active list, decide and a first result; when a spill moves a victim's
// register, a second result follows in the cycle after the first. Results
// appear for one cycle each on result_valid and cannot be stalled; last_result
// marks the final one of an item. Expiry and the register choice each make one
// pass over all 16 active entries in parallel. Configuration writes are always
// ready and should be issued only while busy is low; writing the pool mask
// reloads the free map.
module linear_scan_register_allocator import lsra_pkg::*; #(
  parameter int NUM_REGS   = 16,
  parameter int MAX_VALUES = 1024,
  parameter int NUM_TYPES  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [POS_W-1:0]     range_start,
  input  logic [POS_W-1:0]     range_end,
  input  logic [TYPE_W-1:0]    value_type,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  output logic                 result_valid,
  output logic [POS_W-1:0]     value_index,
  output logic                 in_register,
  output logic [3:0]           register_number,
  output logic [POS_W-1:0]     stack_slot,
  output logic                 last_result
);

  lsra_cmd_t  cmd;
  lsra_stat_t stat;

  // Config port never pushes back.
  assign cfg_ready = 1'b1;

  lsra_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  lsra_dp #(
    .NUM_REGS  (NUM_REGS),
    .MAX_VALUES(MAX_VALUES),
    .NUM_TYPES (NUM_TYPES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .range_start    (range_start),
    .range_end      (range_end),
    .value_type     (value_type),
    .result_valid   (result_valid),
    .value_index    (value_index),
    .in_register    (in_register),
    .register_number(register_number),
    .stack_slot     (stack_slot),
    .last_result    (last_result)
  );

endmodule
